@@ rtl/signed_divider_saturating_defines.svh @@
// ----------------------------------------------------------------------------
// Signed divider assertion macros
// Shared property shorthands for the divider checker.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DIVIDER_SATURATING_DEFINES_SVH
`define SIGNED_DIVIDER_SATURATING_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define SDIVSAT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("divider check failed");

// Next-cycle implication, disabled while reset is low
`define SDIVSAT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("divider check failed");

`endif

@@ rtl/sdivsat_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed divider package
// Control word that travels down the divider pipeline beside the data.
// ----------------------------------------------------------------------------
package sdivsat_pkg;

  typedef struct packed {
    logic valid;     // stage holds a live word
    logic q_neg;     // operand signs differ
    logic div_zero;  // divisor was zero
  } sdivsat_ctl_t;

endpackage

@@ rtl/signed_divider_saturating.sv @@
// ----------------------------------------------------------------------------
// Saturating signed divider
// Pipelined restoring divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       consumer   in_valid_i / in_ready_o   dividend_i, divisor_i
// out      producer   out_valid_o / out_ready_i quotient_o
//
// Stages: one operand stage, one stage per quotient
// bit, one result stage. A new word may enter every cycle unless a result waits unread.
// The whole pipeline advances together; it holds while a result waits unread.
// Reset clears only the control words and valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module signed_divider_saturating #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] dividend_i,
  input  logic signed [DATA_WIDTH-1:0] divisor_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] quotient_o
);

  logic                      adv;
  sdivsat_pkg::sdivsat_ctl_t ctl  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]     rem  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]     nq   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]     dmag [DATA_WIDTH+1];

  // advance when the output register is empty or being read
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  sdivsat_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (in_valid_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .ctl_o      (ctl[0]),
    .rem_o      (rem[0]),
    .nq_o       (nq[0]),
    .dmag_o     (dmag[0])
  );

  for (genvar s = 0; s < DATA_WIDTH; s++) begin : g_step
    sdivsat_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (ctl[s]),
      .rem_i  (rem[s]),
      .nq_i   (nq[s]),
      .dmag_i (dmag[s]),
      .ctl_o  (ctl[s+1]),
      .rem_o  (rem[s+1]),
      .nq_o   (nq[s+1]),
      .dmag_o (dmag[s+1])
    );
  end

  sdivsat_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .ctl_i      (ctl[DATA_WIDTH]),
    .q_mag_i    (nq[DATA_WIDTH]),
    .valid_o    (out_valid_o),
    .quotient_o (quotient_o)
  );

endmodule

@@ rtl/sdivsat_prep.sv @@
// ----------------------------------------------------------------------------
// Signed divider operand stage
// Registers operand magnitudes, result sign and the zero-divisor flag.
// ----------------------------------------------------------------------------
module sdivsat_prep #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic signed [DATA_WIDTH-1:0] dividend_i,
  input  logic signed [DATA_WIDTH-1:0] divisor_i,
  output sdivsat_pkg::sdivsat_ctl_t    ctl_o,
  output logic        [DATA_WIDTH-1:0] rem_o,
  output logic        [DATA_WIDTH-1:0] nq_o,
  output logic        [DATA_WIDTH-1:0] dmag_o
);

  logic                      n_neg;
  logic                      d_neg;
  logic [DATA_WIDTH-1:0]     nmag_d;
  logic [DATA_WIDTH-1:0]     dmag_d;
  sdivsat_pkg::sdivsat_ctl_t ctl_d;
  sdivsat_pkg::sdivsat_ctl_t ctl_q;
  logic [DATA_WIDTH-1:0]     nmag_q;
  logic [DATA_WIDTH-1:0]     dmag_q;

  always_comb begin
    n_neg  = dividend_i[DATA_WIDTH-1];
    d_neg  = divisor_i[DATA_WIDTH-1];
    // most negative value maps onto 2^(W-1), which still fits unsigned
    nmag_d = n_neg ? ({DATA_WIDTH{1'b0}} - dividend_i) : dividend_i;
    dmag_d = d_neg ? ({DATA_WIDTH{1'b0}} - divisor_i) : divisor_i;
    ctl_d.valid    = valid_i;
    ctl_d.q_neg    = n_neg ^ d_neg;
    ctl_d.div_zero = (divisor_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      nmag_q <= nmag_d;
      dmag_q <= dmag_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = '0;
  assign nq_o   = nmag_q;
  assign dmag_o = dmag_q;

endmodule

@@ rtl/sdivsat_step.sv @@
// ----------------------------------------------------------------------------
// Signed divider quotient step
// One restoring shift-subtract step: retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module sdivsat_step #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  sdivsat_pkg::sdivsat_ctl_t ctl_i,
  input  logic [DATA_WIDTH-1:0]     rem_i,
  input  logic [DATA_WIDTH-1:0]     nq_i,
  input  logic [DATA_WIDTH-1:0]     dmag_i,
  output sdivsat_pkg::sdivsat_ctl_t ctl_o,
  output logic [DATA_WIDTH-1:0]     rem_o,
  output logic [DATA_WIDTH-1:0]     nq_o,
  output logic [DATA_WIDTH-1:0]     dmag_o
);

  logic [DATA_WIDTH-1:0]     trial;
  logic                      q_bit;
  logic [DATA_WIDTH-1:0]     rem_d;
  logic [DATA_WIDTH-1:0]     nq_d;
  sdivsat_pkg::sdivsat_ctl_t ctl_q;
  logic [DATA_WIDTH-1:0]     rem_q;
  logic [DATA_WIDTH-1:0]     nq_q;
  logic [DATA_WIDTH-1:0]     dmag_q;

  // Remainder stays below the divisor magnitude, so the shifted value fits.
  // Dividend bits shift out of the top of nq while quotient bits enter below.
  always_comb begin
    trial = {rem_i[DATA_WIDTH-2:0], nq_i[DATA_WIDTH-1]};
    q_bit = (trial >= dmag_i);
    rem_d = q_bit ? (trial - dmag_i) : trial;
    nq_d  = {nq_i[DATA_WIDTH-2:0], q_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      dmag_q <= dmag_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign nq_o   = nq_q;
  assign dmag_o = dmag_q;

endmodule

@@ rtl/sdivsat_post.sv @@
// ----------------------------------------------------------------------------
// Signed divider result stage
// Applies the sign, saturates and holds the result word for the consumer.
// ----------------------------------------------------------------------------
module sdivsat_post #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  sdivsat_pkg::sdivsat_ctl_t    ctl_i,
  input  logic        [DATA_WIDTH-1:0] q_mag_i,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH-1:0] quotient_o
);

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic [DATA_WIDTH-1:0] quo_d;
  logic [DATA_WIDTH-1:0] quo_q;
  logic                  valid_q;

  always_comb begin
    if (ctl_i.div_zero) begin
      quo_d = MaxPos;
    end else if (ctl_i.q_neg) begin
      quo_d = {DATA_WIDTH{1'b0}} - q_mag_i;
    end else if (q_mag_i[DATA_WIDTH-1]) begin
      // most negative over minus one
      quo_d = MaxPos;
    end else begin
      quo_d = q_mag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      quo_q <= quo_d;
    end
  end

  assign valid_o    = valid_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/sdivsat_checker.sv @@
// ----------------------------------------------------------------------------
// Signed divider port checker
// Watches the divider ports for handshake and back-pressure slips.
// ----------------------------------------------------------------------------
`include "signed_divider_saturating_defines.svh"

module sdivsat_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [DATA_WIDTH-1:0] quotient_o
);

  `SDIVSAT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  `SDIVSAT_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(quotient_o))

  `SDIVSAT_ASSERT_NOW(a_stall_blocks_in, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)

  `SDIVSAT_ASSERT_NOW(a_empty_takes_in, clk_i, rst_ni, !out_valid_o || out_ready_i, in_ready_o)

endmodule

bind signed_divider_saturating sdivsat_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sdivsat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .quotient_o  (quotient_o)
);

@@ dv/quotient_checker.sv @@
// ----------------------------------------------------------------------------
// Signed divider quotient checker
// Watches both channels of the divider, works out the truncated quotient of
// every word taken in and compares it with each quotient handed out, in order.
// ----------------------------------------------------------------------------
module quotient_checker #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [DATA_WIDTH-1:0] quotient_i,
  output int                    mismatch_count_o,
  output int                    pending_o,
  output int                    compared_o
);

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic [W-1:0] quo;
  } quotient_due_t;

  quotient_due_t quotient_due_q[$];

  // Restoring division on the magnitudes, sign applied afterwards
  function automatic logic [W-1:0] trunc_quotient(logic [W-1:0] num, logic [W-1:0] den);
    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic         num_neg;
    logic         den_neg;
    num_neg = num[W-1];
    den_neg = den[W-1];
    num_mag = num_neg ? -num : num;
    den_mag = den_neg ? -den : den;
    if (den_mag == '0) return MAX_POS;
    rem = '0;
    quo = '0;
    for (int i = W - 1; i >= 0; i--) begin
      rem = {rem[W-2:0], num_mag[i]};
      quo = {quo[W-2:0], 1'b0};
      if (rem >= den_mag) begin
        rem = rem - den_mag;
        quo[0] = 1'b1;
      end
    end
    if (num_neg != den_neg) return -quo;
    // only most negative over minus one lands here
    if (quo > MAX_POS) return MAX_POS;
    return quo;
  endfunction

  always @(posedge clk_i) begin : watch
    quotient_due_t head;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        quotient_due_q.push_back('{dividend_i, divisor_i,
                                   trunc_quotient(dividend_i, divisor_i)});
      if (out_valid_i && out_ready_i) begin
        if (quotient_due_q.size() == 0) begin
          $display("%0t: quotient %h with no word outstanding", $time, quotient_i);
          mismatch_count_o++;
        end else begin
          head = quotient_due_q.pop_front();
          compared_o++;
          if (quotient_i !== head.quo) begin
            $display("%0t: %h / %h expected %h actual %h",
                     $time, head.num, head.den, head.quo, quotient_i);
            mismatch_count_o++;
          end
        end
      end
      pending_o = quotient_due_q.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Signed divider testbench
// Feeds corner and random operand pairs through the divider under random
// gaps and back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int W = 32;
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ONE     = 1;
  localparam logic [W-1:0] NEG_ONE = '1;
  localparam int RANDOM_WORDS  = 400;
  localparam int HOLD_START    = 150;
  localparam int HOLD_CYCLES   = 100;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_ready_o;
  logic [W-1:0] dividend_i;
  logic [W-1:0] divisor_i;
  logic         out_valid_o;
  logic         out_ready_i;
  logic [W-1:0] quotient_o;

  int mismatch_count;
  int pending;
  int compared;
  int sent_count;

  signed_divider_saturating #(
    .DATA_WIDTH(W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .quotient_o (quotient_o)
  );

  quotient_checker #(
    .DATA_WIDTH(W)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .dividend_i      (dividend_i),
    .divisor_i       (divisor_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .quotient_i      (quotient_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .compared_o      (compared)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(12 * 200000);
    $display("== FAIL ==");
    $finish;
  end

  // Offer one word, idling first at random outside the steady stretch
  task automatic send_word(input logic [W-1:0] num, input logic [W-1:0] den);
    if (sent_count < 150 || sent_count >= 250) begin
      while ($urandom_range(99) < 31) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    dividend_i <= num;
    divisor_i  <= den;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  // Receiver: random stalls, one long hold-off, a later steady stretch, then random stalls again
  initial begin
    int cyc;
    cyc = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
        out_ready_i <= 1'b0;
      else if (cyc >= 500 && cyc < 800)
        out_ready_i <= 1'b1;
      else
        out_ready_i <= ($urandom_range(99) >= 31);
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    dividend_i = '0;
    divisor_i  = '0;
    sent_count = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero divisor, overflow and sign corners
    send_word(MIN_NEG, NEG_ONE);
    send_word(MIN_NEG, ONE);
    send_word(MIN_NEG, '0);
    send_word('0, '0);
    send_word(MAX_POS, '0);
    send_word(NEG_ONE, '0);
    send_word(MAX_POS, ONE);
    send_word(MAX_POS, NEG_ONE);
    send_word(MIN_NEG, MIN_NEG);
    send_word(MAX_POS, MAX_POS);
    send_word(MIN_NEG, MAX_POS);
    send_word(MAX_POS, MIN_NEG);
    send_word(ONE, MIN_NEG);
    send_word(NEG_ONE, MIN_NEG);
    send_word(32'd5, 32'd7);
    send_word(-32'sd5, 32'd7);
    send_word(-32'sd7, 32'd2);
    send_word(32'd7, -32'sd2);
    send_word(-32'sd7, -32'sd2);
    send_word(32'd100, 32'd3);
    send_word('0, 32'd5);
    send_word(NEG_ONE, NEG_ONE);
    send_word(32'hAAAA_AAAA, 32'h5555_5555);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      logic [W-1:0] num;
      logic [W-1:0] den;
      num = $urandom;
      den = $urandom;
      case ($urandom_range(9))
        4: begin
          den = $urandom_range(255);
          if ($urandom_range(1)) den = -den;
        end
        5: begin
          case ($urandom_range(4))
            0: den = '0;
            1: den = ONE;
            2: den = NEG_ONE;
            3: den = MIN_NEG;
            default: den = MAX_POS;
          endcase
          if ($urandom_range(1)) num = MIN_NEG;
        end
        6: begin
          case ($urandom_range(3))
            0: num = MIN_NEG;
            1: num = MAX_POS;
            2: num = '0;
            default: num = NEG_ONE;
          endcase
        end
        7: begin
          num = $urandom_range(1000);
          den = $urandom_range(40);
          if ($urandom_range(1)) num = -num;
          if ($urandom_range(1)) den = -den;
        end
        8: begin
          num = $signed(num) >>> $urandom_range(W - 1);
          den = $signed(den) >>> $urandom_range(W - 1);
        end
        9: den = $urandom_range(1) ? num : -num;
        default: ;
      endcase
      send_word(num, den);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (W + 8) @(posedge clk_i);

    $display("Sent %0d words: zero divisors, most negative by +/-1, mixed signs, random operands",
             sent_count);
    $display("Compared %0d quotients; output held off %0d cycles to back up the pipeline",
             compared, HOLD_CYCLES);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sdivsat_pkg.sv
rtl/sdivsat_prep.sv
rtl/sdivsat_step.sv
rtl/sdivsat_post.sv
rtl/signed_divider_saturating.sv
rtl/sdivsat_checker.sv
dv/quotient_checker.sv
dv/tb.sv
